[rtl/sync_length_checksum_deframer_defines.svh]
// assertion macros for the sync/length/checksum deframer
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS
`define SLCD_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("slcd assertion failed");
`define SLCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slcd assertion failed");
`else
`define SLCD_ASSERT(label, cond)
`define SLCD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/slcd_pkg.sv]
package slcd_pkg;

  localparam logic [7:0] SYNC_BYTE      = 8'h0F;
  localparam int         LEN_POS        = 3;
  localparam logic [8:0] FRAME_OVERHEAD = 9'd5;

  typedef enum logic [2:0] {
    ST_HUNT    = 3'b001,
    ST_COLLECT = 3'b010,
    ST_EMIT    = 3'b100
  } state_t;

  // control group to the frame store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

endpackage

[rtl/slcd_store.sv]
module slcd_store
  import slcd_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  store_ctl_t    ctl,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/sync_length_checksum_deframer.sv]
// input: one word per cycle while hunting or collecting; no result for non-final words
// a good frame is read out once its checksum word is taken, one word at a time
// (store read, then output register load), held by output stalls; in_ready is
// low until its last word is loaded; the frame store has a single read port
// reset: synchronous, hunts for sync with an empty output; store contents left as is
`include "sync_length_checksum_deframer_defines.svh"

module sync_length_checksum_deframer
  import slcd_pkg::*;
#(
  parameter int MAX_FRAME = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] frame_byte,
  output logic       frame_last
);

  localparam int AW = $clog2(MAX_FRAME);

  state_t        state, state_next;
  logic [AW-1:0] pos, pos_next;
  logic [AW-1:0] last_idx, last_idx_next;
  logic [7:0]    running_sum, running_sum_next;
  logic [AW-1:0] rd_idx, rd_idx_next;
  logic          rd_pend, rd_pend_next;
  logic          out_valid_next;
  logic [7:0]    frame_byte_next;
  logic          frame_last_next;

  store_ctl_t    store_ctl;
  logic [7:0]    rd_data;
  logic          accept;
  logic          out_free;
  logic [8:0]    total;
  logic          has_len;

  assign in_ready = (state != ST_EMIT);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign total    = {1'b0, rx_byte} + FRAME_OVERHEAD;
  assign has_len  = (pos > AW'(LEN_POS));

  slcd_store #(
    .DEPTH (MAX_FRAME),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .ctl     (store_ctl),
    .wr_addr (pos),
    .wr_data (rx_byte),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next       = state;
    pos_next         = pos;
    last_idx_next    = last_idx;
    running_sum_next = running_sum;
    rd_idx_next      = rd_idx;
    rd_pend_next     = rd_pend;
    out_valid_next   = out_valid && !out_ready;
    frame_byte_next  = frame_byte;
    frame_last_next  = frame_last;
    store_ctl        = '0;

    unique case (state)
      ST_HUNT: begin
        if (accept && rx_byte == SYNC_BYTE) begin
          store_ctl.wr_en  = 1'b1;
          pos_next         = AW'(1);
          running_sum_next = '0;
          state_next       = ST_COLLECT;
        end
      end
      ST_COLLECT: begin
        if (accept) begin
          priority if (pos == AW'(LEN_POS) &&
                       (rx_byte == 8'd0 || total > 9'(MAX_FRAME))) begin
            pos_next   = '0;
            state_next = ST_HUNT;
          end else if (has_len && pos == last_idx) begin
            // checksum word: keep it in the store so the frame reads out whole
            if (rx_byte == running_sum) begin
              store_ctl.wr_en = 1'b1;
              rd_idx_next     = '0;
              rd_pend_next    = 1'b0;
              state_next      = ST_EMIT;
            end else begin
              state_next = ST_HUNT;
            end
            pos_next = '0;
          end else begin
            store_ctl.wr_en  = 1'b1;
            running_sum_next = running_sum + rx_byte;
            pos_next         = pos + AW'(1);
            if (pos == AW'(LEN_POS)) begin
              last_idx_next = AW'(total - 9'd1);
            end
          end
        end
      end
      ST_EMIT: begin
        if (!rd_pend) begin
          store_ctl.rd_en = 1'b1;
          rd_pend_next    = 1'b1;
        end else if (out_free) begin
          out_valid_next  = 1'b1;
          frame_byte_next = rd_data;
          frame_last_next = (rd_idx == last_idx);
          rd_pend_next    = 1'b0;
          if (rd_idx == last_idx) begin
            state_next = ST_HUNT;
          end else begin
            rd_idx_next = rd_idx + AW'(1);
          end
        end
      end
      default: begin
        state_next = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_HUNT;
      pos         <= '0;
      last_idx    <= '0;
      running_sum <= '0;
      rd_idx      <= '0;
      rd_pend     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      pos         <= pos_next;
      last_idx    <= last_idx_next;
      running_sum <= running_sum_next;
      rd_idx      <= rd_idx_next;
      rd_pend     <= rd_pend_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    frame_byte <= frame_byte_next;
    frame_last <= frame_last_next;
  end

  `SLCD_ASSERT(a_pend_only_emit, !rd_pend || state == ST_EMIT)
  `SLCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(frame_byte) && $stable(frame_last))
  `SLCD_ASSERT_NEXT(a_zero_len_drops, accept && state == ST_COLLECT && pos == AW'(LEN_POS) && rx_byte == 8'd0, state == ST_HUNT)
  `SLCD_ASSERT(a_pos_bounded, !(state == ST_COLLECT && has_len) || pos <= last_idx)

endmodule
